FILE: hw/rtl/kli_pkg.sv
// Shared types and constants for the keyframe linear interpolator.
// Holds command and register codes, the control word layout and the microprogram.
// No dependencies.
package kli_pkg;

  localparam int CMD_W   = 2;
  localparam int DELTA_W = 16;
  localparam int FRAC_W  = 17;
  localparam int KC_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int PC_W    = 4;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
  localparam logic [3:0] DIV_STEPS_M1 = 4'd15;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEYFRAME_COUNT = 1'd1;

  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_ADVANCE = 4'd1;
  localparam logic [3:0] OP_CHECK   = 4'd2;
  localparam logic [3:0] OP_LATCH_A = 4'd3;
  localparam logic [3:0] OP_LATCH_B = 4'd4;
  localparam logic [3:0] OP_FRAC    = 4'd5;
  localparam logic [3:0] OP_DIV     = 4'd6;
  localparam logic [3:0] OP_EMIT    = 4'd7;

  localparam logic [1:0] ADDR_NONE  = 2'd0;
  localparam logic [1:0] ADDR_CURC1 = 2'd1;
  localparam logic [1:0] ADDR_SEG   = 2'd2;
  localparam logic [1:0] ADDR_SEG1  = 2'd3;

  localparam logic [1:0] COND_NONE        = 2'd0;
  localparam logic [1:0] COND_NOT_PLAYING = 2'd1;
  localparam logic [1:0] COND_FRAC_DIRECT = 2'd2;
  localparam logic [1:0] COND_DIV_MORE    = 2'd3;

  localparam logic [PC_W-1:0] PC_DIV = 4'd7;
  localparam logic [PC_W-1:0] PC_MUL = 4'd8;
  localparam logic [PC_W-1:0] PC_END = 4'd13;

  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      addr_sel;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
    logic            mul_en;
    logic [1:0]      mul_lane;
    logic            acc_en;
    logic [1:0]      acc_lane;
    logic            last;
  } kli_ctl_t;

  typedef struct packed {
    logic not_playing;
    logic frac_direct;
    logic div_more;
  } kli_cond_t;

  function automatic kli_ctl_t cw(logic [3:0] op, logic [1:0] addr_sel, logic [1:0] cond,
                                  logic [PC_W-1:0] target, logic mul_en,
                                  logic [1:0] mul_lane, logic acc_en,
                                  logic [1:0] acc_lane, logic last);
    kli_ctl_t w;
    w.op       = op;
    w.addr_sel = addr_sel;
    w.cond     = cond;
    w.target   = target;
    w.mul_en   = mul_en;
    w.mul_lane = mul_lane;
    w.acc_en   = acc_en;
    w.acc_lane = acc_lane;
    w.last     = last;
    return w;
  endfunction

  function automatic kli_ctl_t kli_rom(logic [PC_W-1:0] pc);
    kli_ctl_t w;
    unique case (pc)
      4'd0:  w = cw(OP_NOP, ADDR_CURC1, COND_NOT_PLAYING, PC_END, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
      4'd1:  w = cw(OP_ADVANCE, ADDR_CURC1, COND_NONE, '0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
      4'd2:  w = cw(OP_CHECK, ADDR_NONE, COND_NONE, '0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
      4'd3:  w = cw(OP_NOP, ADDR_SEG, COND_NONE, '0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
      4'd4:  w = cw(OP_LATCH_A, ADDR_SEG1, COND_NONE, '0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
      4'd5:  w = cw(OP_LATCH_B, ADDR_NONE, COND_NONE, '0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
      4'd6:  w = cw(OP_FRAC, ADDR_NONE, COND_FRAC_DIRECT, PC_MUL,
                    1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
      4'd7:  w = cw(OP_DIV, ADDR_NONE, COND_DIV_MORE, PC_DIV, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
      4'd8:  w = cw(OP_NOP, ADDR_NONE, COND_NONE, '0, 1'b1, 2'd0, 1'b0, 2'd0, 1'b0);
      4'd9:  w = cw(OP_NOP, ADDR_NONE, COND_NONE, '0, 1'b1, 2'd1, 1'b1, 2'd0, 1'b0);
      4'd10: w = cw(OP_NOP, ADDR_NONE, COND_NONE, '0, 1'b1, 2'd2, 1'b1, 2'd1, 1'b0);
      4'd11: w = cw(OP_NOP, ADDR_NONE, COND_NONE, '0, 1'b0, 2'd0, 1'b1, 2'd2, 1'b0);
      4'd12: w = cw(OP_EMIT, ADDR_NONE, COND_NONE, '0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
      default: w = cw(OP_NOP, ADDR_NONE, COND_NONE, '0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/kli_in_if.sv
// Request channel of the keyframe linear interpolator.
// Carries valid, ready and one command with its fields; uses kli_pkg.
interface kli_in_if
  import kli_pkg::*;
#(
  parameter int IDX_W = 4,
  parameter int TIME_W = 24,
  parameter int VAL_W = 16
);
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [DELTA_W-1:0]      delta_ticks;
  logic [IDX_W-1:0]        key_index;
  logic [TIME_W-1:0]       key_time;
  logic signed [VAL_W-1:0] key_x;
  logic signed [VAL_W-1:0] key_y;
  logic signed [VAL_W-1:0] key_z;

  modport source (output valid, command, delta_ticks, key_index, key_time, key_x, key_y,
                  key_z, input ready);
  modport sink (input valid, command, delta_ticks, key_index, key_time, key_x, key_y,
                key_z, output ready);
endinterface

FILE: hw/rtl/kli_out_if.sv
// Result channel of the keyframe linear interpolator.
// Carries valid, ready and one interpolated sample; uses kli_pkg.
interface kli_out_if
  import kli_pkg::*;
#(
  parameter int IDX_W = 4,
  parameter int VAL_W = 16
);
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_x;
  logic signed [VAL_W-1:0] out_y;
  logic signed [VAL_W-1:0] out_z;
  logic [IDX_W-1:0]        segment_index;
  logic [FRAC_W-1:0]       fraction;
  logic                    finished;

  modport source (output valid, out_x, out_y, out_z, segment_index, fraction, finished,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, segment_index, fraction, finished,
                output ready);
endinterface

FILE: hw/rtl/kli_key_ram.sv
// Keyframe table: one write port and one registered read port.
// Standalone memory, no package dependencies.
module kli_key_ram #(
  parameter int DEPTH = 16,
  parameter int AW = 4,
  parameter int DW = 72
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/kli_seq.sv
// Microprogram sequencer: step counter, control store and conditional jumps.
// Depends on kli_pkg for the control word, condition bundle and program.
module kli_seq
  import kli_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      stall,
  input  kli_cond_t conds,
  output logic      busy,
  output kli_ctl_t  ctl
);
  logic [PC_W-1:0] pc;
  logic            taken;

  assign ctl = kli_rom(pc);

  always_comb begin
    unique case (ctl.cond)
      COND_NOT_PLAYING: taken = conds.not_playing;
      COND_FRAC_DIRECT: taken = conds.frac_direct;
      COND_DIV_MORE:    taken = conds.div_more;
      default:          taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= '0;
    end else if (busy && !stall) begin
      priority if (ctl.last) begin
        busy <= 1'b0;
      end else if (taken) begin
        pc <= ctl.target;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end
endmodule

FILE: hw/rtl/keyframe_linear_interpolator.sv
// Keyframe linear interpolator. Load and play requests take effect when accepted. A tick while
// playing runs a microprogram over a shared datapath, using the 16-step restoring divider
// when the fraction needs it and skipping it when the fraction is 0 or 1.0 directly; when the
// timeline is stopped the program jumps to its end. The next request is taken when the program
// ends. The result waits in an output register, so a stalled result only holds the program at
// its emit step. Depends on kli_pkg, kli_in_if, kli_out_if, kli_key_ram and kli_seq.
module keyframe_linear_interpolator
  import kli_pkg::*;
#(
  parameter int MAX_KEYFRAMES = 16,
  parameter int VALUE_WIDTH = 16,
  parameter int TIME_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  kli_in_if.sink                cmd,
  kli_out_if.source             res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int IDX_W = $clog2(MAX_KEYFRAMES);
  localparam int CNT_W = $clog2(MAX_KEYFRAMES + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int DW = TW + 3 * VW;
  localparam int SUM_W = ((TW > DELTA_W) ? TW : DELTA_W) + 1;
  localparam int PROD_W = VW + 19;
  localparam logic [IDX_W:0] MAX_K = (IDX_W + 1)'(MAX_KEYFRAMES);
  localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'({TW{1'b1}});

  logic            loop_enable;
  logic [KC_W-1:0] keyframe_count;
  logic            playing;
  logic [TW-1:0]   elapsed;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] seg;
  logic            fin;
  logic [FRAC_W-1:0] frac;
  logic [TW-1:0]   t0;
  logic [TW-1:0]   t1;
  logic [TW-1:0]   rem;
  logic [TW-1:0]   dvs;
  logic [3:0]      divcnt;
  logic [VW-1:0]   a_v [3];
  logic [VW-1:0]   b_v [3];
  logic [VW-1:0]   res_v [3];
  logic signed [PROD_W-1:0] prod;
  logic [DELTA_W-1:0] cmd_delta;

  logic            busy;
  kli_ctl_t        ctl;
  kli_cond_t       conds;
  logic            start;
  logic            stall;
  logic            emit_go;
  logic            mem_we;
  logic [IDX_W-1:0] raddr;
  logic [DW-1:0]   rd_data;
  logic [TW-1:0]   rd_time;
  logic [VW-1:0]   rd_v [3];
  logic [CNT_W-1:0] cnt_c;
  logic [IDX_W-1:0] last1;
  logic [IDX_W-1:0] last2;
  logic [IDX_W-1:0] cur_c;
  logic [IDX_W-1:0] cur_inc;
  logic [SUM_W-1:0] sum;
  logic [TW-1:0]   elapsed_next;
  logic            adv;
  logic            at_end;
  logic [TW:0]     r2;
  logic            ge;
  logic signed [VW:0] diff;

  assign cmd.ready = !busy;
  assign start  = cmd.valid && cmd.ready && (cmd.command == CMD_TICK);
  assign mem_we = cmd.valid && cmd.ready && (cmd.command == CMD_LOAD) &&
                  ({1'b0, cmd.key_index} < MAX_K);
  assign stall   = busy && (ctl.op == OP_EMIT) && res.valid && !res.ready;
  assign emit_go = busy && (ctl.op == OP_EMIT) && !stall;

  kli_key_ram #(
    .DEPTH (MAX_KEYFRAMES),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cmd.key_index),
    .wdata ({cmd.key_z, cmd.key_y, cmd.key_x, cmd.key_time}),
    .raddr (raddr),
    .rdata (rd_data)
  );

  kli_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stall (stall),
    .conds (conds),
    .busy  (busy),
    .ctl   (ctl)
  );

  always_comb begin
    rd_time = rd_data[TW-1:0];
    for (int l = 0; l < 3; l++) begin
      rd_v[l] = rd_data[TW + l * VW +: VW];
    end
  end

  always_comb begin
    if (keyframe_count < 5'd2) begin
      cnt_c = CNT_W'(2);
    end else if (32'(keyframe_count) > 32'(MAX_KEYFRAMES)) begin
      cnt_c = CNT_W'(MAX_KEYFRAMES);
    end else begin
      cnt_c = CNT_W'(keyframe_count);
    end
    last1 = IDX_W'(cnt_c - CNT_W'(1));
    last2 = IDX_W'(cnt_c - CNT_W'(2));
    cur_c = (cur > last2) ? last2 : cur;
    cur_inc = cur + 1'b1;
    adv = rd_time <= elapsed;
    at_end = cur_inc == last1;
    sum = SUM_W'(elapsed) + SUM_W'(cmd_delta);
    elapsed_next = (sum > TIME_MAX) ? TW'(TIME_MAX) : TW'(sum);
    r2 = {rem, 1'b0};
    ge = r2 >= {1'b0, dvs};
    diff = $signed({b_v[ctl.mul_lane][VW-1], b_v[ctl.mul_lane]}) -
           $signed({a_v[ctl.mul_lane][VW-1], a_v[ctl.mul_lane]});
  end

  always_comb begin
    unique case (ctl.addr_sel)
      ADDR_CURC1: raddr = cur_c + 1'b1;
      ADDR_SEG1:  raddr = seg + 1'b1;
      default:    raddr = seg;
    endcase
  end

  assign conds.not_playing = !playing;
  assign conds.frac_direct = fin || (t1 <= t0) || (elapsed <= t0) || (elapsed >= t1);
  assign conds.div_more    = divcnt != 4'd0;

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_delta <= cmd.delta_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable    <= 1'b0;
      keyframe_count <= KC_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOOP_ENABLE:    loop_enable <= cfg_data[0];
        REG_KEYFRAME_COUNT: keyframe_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing <= 1'b1;
      elapsed <= '0;
      cur     <= '0;
    end else if (cmd.valid && cmd.ready && (cmd.command == CMD_PLAY)) begin
      playing <= 1'b1;
      elapsed <= '0;
      cur     <= '0;
    end else if (busy && (ctl.op == OP_ADVANCE)) begin
      elapsed <= elapsed_next;
      cur     <= cur_c;
    end else if (busy && (ctl.op == OP_CHECK)) begin
      priority if (adv && at_end && loop_enable) begin
        elapsed <= '0;
        cur     <= '0;
      end else if (adv && at_end) begin
        playing <= 1'b0;
        cur     <= last1;
      end else if (adv) begin
        cur <= cur_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      unique case (ctl.op)
        OP_CHECK: begin
          fin <= adv && at_end && !loop_enable;
          priority if (adv && at_end && loop_enable) begin
            seg <= '0;
          end else if (adv && at_end) begin
            frac <= FRAC_ONE;
            seg  <= last2;
          end else if (adv) begin
            seg <= cur_inc;
          end else begin
            seg <= cur;
          end
        end
        OP_LATCH_A: begin
          t0 <= rd_time;
          for (int l = 0; l < 3; l++) begin
            a_v[l] <= rd_v[l];
          end
        end
        OP_LATCH_B: begin
          t1 <= rd_time;
          for (int l = 0; l < 3; l++) begin
            b_v[l] <= rd_v[l];
          end
        end
        OP_FRAC: begin
          priority if (fin) begin
            frac <= frac;
          end else if (t1 <= t0) begin
            frac <= FRAC_ONE;
          end else if (elapsed <= t0) begin
            frac <= '0;
          end else if (elapsed >= t1) begin
            frac <= FRAC_ONE;
          end else begin
            frac   <= '0;
            rem    <= elapsed - t0;
            dvs    <= t1 - t0;
            divcnt <= DIV_STEPS_M1;
          end
        end
        OP_DIV: begin
          rem    <= ge ? TW'(r2 - {1'b0, dvs}) : TW'(r2);
          frac   <= {frac[FRAC_W-2:0], ge};
          divcnt <= divcnt - 4'd1;
        end
        default: ;
      endcase
      if (ctl.mul_en) begin
        prod <= PROD_W'(diff * $signed({1'b0, frac}));
      end
      if (ctl.acc_en) begin
        res_v[ctl.acc_lane] <= a_v[ctl.acc_lane] + prod[VW+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit_go) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      res.out_x         <= res_v[0];
      res.out_y         <= res_v[1];
      res.out_z         <= res_v[2];
      res.segment_index <= seg;
      res.fraction      <= frac;
      res.finished      <= fin;
    end
  end
endmodule
